// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int VALUE_WIDTH = 32;
	localparam int OP_WIDTH    = 4;
	localparam int DVD_WIDTH   = VALUE_WIDTH + FRAC_BITS;
	localparam int DIV_STEPS   = DVD_WIDTH;
	localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_MIN      = 4'd4,
		OP_MAX      = 4'd5,
		OP_INC      = 4'd6,
		OP_DEC      = 4'd7,
		OP_TO_INT   = 4'd8,
		OP_FROM_INT = 4'd9
	} op_t;

	typedef struct packed {
		logic                   use_div;
		logic                   neg;
		logic [VALUE_WIDTH-1:0] rem;
		logic [DVD_WIDTH-1:0]   dvd;
		logic [VALUE_WIDTH-1:0] dsr;
		logic [VALUE_WIDTH-1:0] quo;
		logic [VALUE_WIDTH-1:0] result;
		logic                   less;
		logic                   equal;
		logic                   greater;
		logic                   dz;
	} lane_t;

endpackage

// ===== rtl/fpa_in_if.sv =====
interface fpa_in_if;
	logic                                valid;
	logic                                ready;
	logic [fpa_pkg::OP_WIDTH-1:0]        operation;
	logic signed [fpa_pkg::VALUE_WIDTH-1:0] operand_a;
	logic signed [fpa_pkg::VALUE_WIDTH-1:0] operand_b;

	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

// ===== rtl/fpa_out_if.sv =====
interface fpa_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fpa_pkg::VALUE_WIDTH-1:0] result_value;
	logic                                   a_less;
	logic                                   a_equal;
	logic                                   a_greater;
	logic                                   divide_by_zero;

	modport source (output valid, result_value, a_less, a_equal, a_greater, divide_by_zero,
		input ready);
	modport sink (input valid, result_value, a_less, a_equal, a_greater, divide_by_zero,
		output ready);
endinterface

// ===== rtl/fpa_front.sv =====
module fpa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	fpa_in_if.sink          operands,
	output logic            valid_s2,
	output fpa_pkg::lane_t  lane_s2
);

	localparam int W = fpa_pkg::VALUE_WIDTH;
	localparam int F = fpa_pkg::FRAC_BITS;

	logic                             valid_s1;
	fpa_pkg::op_t                     op_s1;
	logic signed [W-1:0]              a_s1;
	logic [W-1:0]                     b_s1;
	logic [W-1:0]                     mag_a_s1;
	logic [W-1:0]                     mag_b_s1;
	logic [fpa_pkg::PROD_WIDTH-1:0]   prod_s1;
	logic                             neg_s1;
	logic                             less_s1;
	logic                             equal_s1;
	logic                             greater_s1;
	logic [W-1:0]                     simple_s1;

	logic signed [W-1:0] a;
	logic signed [W-1:0] b;
	logic [W-1:0]        mag_a;
	logic [W-1:0]        mag_b;
	logic                less;
	logic                greater;
	logic [W-1:0]        simple;
	logic [W-1:0]        mul_mag;
	logic [W-1:0]        mul_res;
	logic                b_zero;
	fpa_pkg::lane_t      lane;

	assign operands.ready = advance;
	assign a       = operands.operand_a;
	assign b       = operands.operand_b;
	assign mag_a   = a[W-1] ? W'(-a) : W'(a);
	assign mag_b   = b[W-1] ? W'(-b) : W'(b);
	assign less    = a < b;
	assign greater = a > b;

	always_comb begin
		case (fpa_pkg::op_t'(operands.operation))
			fpa_pkg::OP_ADD:      simple = W'(a + b);
			fpa_pkg::OP_SUB:      simple = W'(a - b);
			fpa_pkg::OP_MIN:      simple = greater ? b : a;
			fpa_pkg::OP_MAX:      simple = less ? b : a;
			fpa_pkg::OP_INC:      simple = W'(a + W'(1));
			fpa_pkg::OP_DEC:      simple = W'(a - W'(1));
			fpa_pkg::OP_TO_INT:   simple = W'(a >>> F);
			fpa_pkg::OP_FROM_INT: simple = W'(a << F);
			default:              simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= operands.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1      <= fpa_pkg::op_t'(operands.operation);
			a_s1       <= a;
			b_s1       <= b;
			mag_a_s1   <= mag_a;
			mag_b_s1   <= mag_b;
			prod_s1    <= mag_a * mag_b;
			neg_s1     <= a[W-1] ^ b[W-1];
			less_s1    <= less;
			equal_s1   <= a == b;
			greater_s1 <= greater;
			simple_s1  <= simple;
		end
	end

	assign mul_mag = prod_s1[F +: W];
	assign mul_res = neg_s1 ? W'(-mul_mag) : mul_mag;
	assign b_zero  = b_s1 == '0;

	always_comb begin
		lane.use_div = (op_s1 == fpa_pkg::OP_DIV) && !b_zero;
		lane.neg     = neg_s1;
		lane.rem     = '0;
		lane.dvd     = {mag_a_s1, {F{1'b0}}};
		lane.dsr     = mag_b_s1;
		lane.quo     = '0;
		lane.less    = less_s1;
		lane.equal   = equal_s1;
		lane.greater = greater_s1;
		lane.dz      = (op_s1 == fpa_pkg::OP_DIV) && b_zero;
		if (op_s1 == fpa_pkg::OP_MUL) begin
			lane.result = mul_res;
		end else if (op_s1 == fpa_pkg::OP_DIV) begin
			lane.result = a_s1;
		end else begin
			lane.result = simple_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lane_s2 <= lane;
		end
	end

endmodule

// ===== rtl/fpa_div_cell.sv =====
module fpa_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid_in,
	input  fpa_pkg::lane_t  lane_in,
	output logic            valid_q,
	output fpa_pkg::lane_t  lane_q
);

	localparam int W = fpa_pkg::VALUE_WIDTH;

	logic [W:0]     trial;
	logic [W:0]     diff;
	fpa_pkg::lane_t lane;

	assign trial = {lane_in.rem, lane_in.dvd[fpa_pkg::DVD_WIDTH-1]};
	assign diff  = trial - {1'b0, lane_in.dsr};

	always_comb begin
		lane     = lane_in;
		lane.dvd = {lane_in.dvd[fpa_pkg::DVD_WIDTH-2:0], 1'b0};
		if (!diff[W]) begin
			lane.rem = diff[W-1:0];
			lane.quo = {lane_in.quo[W-2:0], 1'b1};
		end else begin
			lane.rem = trial[W-1:0];
			lane.quo = {lane_in.quo[W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lane_q <= lane;
		end
	end

endmodule

// ===== rtl/fpa_finish.sv =====
module fpa_finish (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  fpa_pkg::lane_t  lane_in,
	output logic            advance,
	fpa_out_if.source       results
);

	localparam int W = fpa_pkg::VALUE_WIDTH;

	logic         valid_q;
	logic [W-1:0] value;

	assign advance = !valid_q || results.ready;

	always_comb begin
		if (lane_in.use_div) begin
			value = lane_in.neg ? W'(-lane_in.quo) : lane_in.quo;
		end else begin
			value = lane_in.result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			results.result_value   <= value;
			results.a_less         <= lane_in.less;
			results.a_equal        <= lane_in.equal;
			results.a_greater      <= lane_in.greater;
			results.divide_by_zero <= lane_in.dz;
		end
	end

	assign results.valid = valid_q;

endmodule

// ===== rtl/fixed_point_alu_core.sv =====
// Signed Q24.8 fixed-point ALU on 32-bit raw values.
// operands: valid/ready channel carrying operation, operand_a, operand_b;
//   a transaction completes when valid and ready are both high.
// results: valid/ready channel carrying result_value and the flags
//   a_less, a_equal, a_greater, divide_by_zero; one per input transaction.
// Throughput: one transaction per cycle, sustained unless a waiting result is held by ready low.
// Pipeline from input transaction to result valid: two front
//   stages (decode, 32x32 multiply, multiply scaling), a chain of 40
//   restoring-divide cells (one quotient bit each), and the output register.
// Every operation rides the full chain, so results leave in input order.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver holds ready low with a result waiting, the whole
//   pipeline holds and operands.ready drops in the same cycle; empty
//   output register lets the pipeline advance regardless of ready.
module fixed_point_alu_core (
	input  logic      clk,
	input  logic      arst_n,
	fpa_in_if.sink    operands,
	fpa_out_if.source results
);

	logic                   advance;
	logic                   valid_c [fpa_pkg::DIV_STEPS+1];
	fpa_pkg::lane_t         lane_c  [fpa_pkg::DIV_STEPS+1];

	fpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.operands (operands),
		.valid_s2 (valid_c[0]),
		.lane_s2  (lane_c[0])
	);

	for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.valid_in (valid_c[i]),
			.lane_in  (lane_c[i]),
			.valid_q  (valid_c[i+1]),
			.lane_q   (lane_c[i+1])
		);
	end

	fpa_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_c[fpa_pkg::DIV_STEPS]),
		.lane_in  (lane_c[fpa_pkg::DIV_STEPS]),
		.advance  (advance),
		.results  (results)
	);

endmodule

// ===== rtl/fpa_checker.sv =====
`include "assert_macros.svh"

module fpa_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [fpa_pkg::VALUE_WIDTH-1:0] result_value,
	input logic                                   a_less,
	input logic                                   a_equal,
	input logic                                   a_greater,
	input logic                                   divide_by_zero
);

	`ASSERT_SAME(a_one_flag, clk, arst_n, out_valid, $onehot({a_less, a_equal, a_greater}))
	`ASSERT_SAME(a_dz_zero, clk, arst_n, out_valid && divide_by_zero && a_equal, result_value == '0)
	`ASSERT_SAME(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_value))

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (operands.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.result_value   (results.result_value),
	.a_less         (results.a_less),
	.a_equal        (results.a_equal),
	.a_greater      (results.a_greater),
	.divide_by_zero (results.divide_by_zero)
);
